/* hdl/prdp_pkg.sv */
`timescale 1ns / 1ps
// Package for the page reuse distance profiler.
// Holds the wave control struct, the controller states and fixed constants.
package prdp_pkg;

  localparam int ADDR_W     = 48;
  localparam int PAGE_SHIFT = 12;
  localparam int CNT_W      = 32;
  localparam int NUM_BINS   = 64;
  localparam int BIN_W      = 6;

  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // Control that travels with the lookup wave from cell to cell.
  typedef struct packed {
    logic             active;        // wave sits at this cell boundary
    logic             found;         // page already matched above
    logic             match_reused;  // reuse mark of the matched entry
    logic             carry_valid;   // entry bumped down from above
    logic             carry_reused;
    logic [BIN_W-1:0] stack_pos;     // depth of the next cell, capped
  } wave_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_BIN,
    ST_FIN
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* hdl/page_reuse_distance_profiler_top.sv */
`timescale 1ns / 1ps
// Top level of the page reuse distance profiler: controller, counters, histogram.
// Depends on prdp_pkg, prdp_cell and prdp_ram.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+---------------------------------------
//   in      | input     | in_valid / in_ready  | mode, address, bin_index
//   out     | output    | out_valid/out_ready  | hit, distance, access_total, miss_total,
//           |           |                      | reused_pages, bin_count
//
// A record word sends a lookup wave down the row of DEPTH cells, one cell per cycle;
// a miss then goes to ST_FIN, a hit first to ST_BIN for the histogram read and
// write through the single-port-pair bin RAM. A bin read word goes ST_BIN, then ST_FIN.
// One word is in work at a time; in_ready is high only while the controller idles.
// The result sits in an output register, so a new word is taken while it waits.
// Reset (rst, synchronous) empties the stack, zeroes the counters and marks every
// histogram bin as zero through its valid bit; no clearing pass is needed.
module page_reuse_distance_profiler_top import prdp_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int PAGE_BITS = 36
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [ADDR_W-1:0] address,
  input  logic [BIN_W-1:0]  bin_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [BIN_W-1:0]  distance,
  output logic [CNT_W-1:0]  access_total,
  output logic [CNT_W-1:0]  miss_total,
  output logic [CNT_W-1:0]  reused_pages,
  output logic [CNT_W-1:0]  bin_count
);

  state_t state, state_next;

  // wave chain through the cells; index 0 is fed here, index DEPTH is the tail
  wave_t                wave      [DEPTH+1];
  logic [PAGE_BITS-1:0] key_chain [DEPTH+1];
  logic [PAGE_BITS-1:0] carry_chain [DEPTH+1];

  logic [ADDR_W-PAGE_SHIFT-1:0] page_raw;
  logic [PAGE_BITS-1:0]         page_in;

  logic             item_mode;
  logic [BIN_W-1:0] bin_addr;
  logic             hit_r;
  logic [BIN_W-1:0] dist_r;
  logic [CNT_W-1:0] bin_r;
  logic [CNT_W-1:0] access_counter;
  logic [CNT_W-1:0] miss_counter;
  logic [CNT_W-1:0] reuse_counter;
  logic [NUM_BINS-1:0] bin_vld;

  logic             wave_start;
  logic             wave_done;
  logic             set_top;
  logic             ram_re;
  logic [BIN_W-1:0] ram_raddr;
  logic             ram_we;
  logic [CNT_W-1:0] ram_rdata;
  logic [CNT_W-1:0] bin_cur;
  logic             load_out;

  // page number: address bits 47..12, zero-extended or cut to PAGE_BITS
  assign page_raw = address[ADDR_W-1:PAGE_SHIFT];
  assign page_in  = PAGE_BITS'(page_raw);

  assign wave_done = wave[DEPTH].active;

  // a never-written bin reads as zero
  assign bin_cur = bin_vld[bin_addr] ? ram_rdata : '0;

  // launch the wave carrying the new page as the entry for the top
  always_comb begin
    wave[0].active       = wave_start;
    wave[0].found        = 1'b0;
    wave[0].match_reused = 1'b0;
    wave[0].carry_valid  = 1'b1;
    wave[0].carry_reused = 1'b0;
    wave[0].stack_pos    = '0;
  end
  assign key_chain[0]   = page_in;
  assign carry_chain[0] = page_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    prdp_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .wave_in    (wave[i]),
      .key_in     (key_chain[i]),
      .carry_in   (carry_chain[i]),
      .set_reused ((i == 0) ? set_top : 1'b0),
      .wave_out   (wave[i+1]),
      .key_out    (key_chain[i+1]),
      .carry_out  (carry_chain[i+1])
    );
  end

  prdp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bin_addr),
    .wdata (sat_inc(bin_cur)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = mode ? ST_BIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (wave_done) begin
          state_next = wave[DEPTH].found ? ST_BIN : ST_FIN;
        end
      end
      ST_BIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready   = 1'b0;
    wave_start = 1'b0;
    set_top    = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = wave[DEPTH].stack_pos;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        wave_start = in_valid && !mode;
        ram_re     = in_valid && mode;
        ram_raddr  = bin_index;
      end
      ST_WALK: begin
        // mark the moved entry at the top and fetch its bin
        set_top = wave_done && wave[DEPTH].found;
        ram_re  = wave_done && wave[DEPTH].found;
      end
      ST_BIN: begin
        ram_we = !item_mode;
      end
      ST_FIN: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      access_counter <= '0;
      miss_counter   <= '0;
      reuse_counter  <= '0;
      bin_vld        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_WALK && wave_done) begin
        access_counter <= sat_inc(access_counter);
        if (!wave[DEPTH].found) begin
          miss_counter <= sat_inc(miss_counter);
        end else if (!wave[DEPTH].match_reused) begin
          reuse_counter <= sat_inc(reuse_counter);
        end
      end
      if (ram_we) begin
        bin_vld[bin_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // word payload held through the walk and the histogram access
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_mode <= mode;
      bin_addr  <= bin_index;
      hit_r     <= 1'b0;
      dist_r    <= '0;
      bin_r     <= '0;
    end
    if (state == ST_WALK && wave_done) begin
      hit_r    <= wave[DEPTH].found;
      dist_r   <= wave[DEPTH].found ? wave[DEPTH].stack_pos : '0;
      bin_addr <= wave[DEPTH].stack_pos;
    end
    if (state == ST_BIN && item_mode) begin
      bin_r <= bin_cur;
    end
    if (load_out) begin
      hit          <= hit_r;
      distance     <= dist_r;
      access_total <= access_counter;
      miss_total   <= miss_counter;
      reused_pages <= reuse_counter;
      bin_count    <= bin_r;
    end
  end

`ifndef SYNTHESIS
  // a miss or a first reuse is always also a counted access
  a_miss_le_access: assert property (@(posedge clk) disable iff (rst)
    miss_counter <= access_counter)
    else $error("miss count exceeds access count");

  a_reuse_le_access: assert property (@(posedge clk) disable iff (rst)
    reuse_counter <= access_counter)
    else $error("reuse count exceeds access count");

  // the tail of the wave only shows up while the controller walks
  a_wave_in_walk: assert property (@(posedge clk) disable iff (rst)
    wave_done |-> state == ST_WALK)
    else $error("lookup wave ended outside the walk");

  // a bin read word never writes the histogram
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !item_mode && $past(state) != ST_IDLE)
    else $error("histogram written by a bin read");

  // a launched wave moves on to the first cell boundary while the controller walks
  a_single_wave: assert property (@(posedge clk) disable iff (rst)
    wave_start |=> state == ST_WALK && wave[1].active)
    else $error("lookup wave launched out of order");
`endif

endmodule

/* hdl/prdp_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module prdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/prdp_cell.sv */
`timescale 1ns / 1ps
// One recency stack entry with its compare and bump-down logic.
// Depends on prdp_pkg for wave_t and the distance cap.
module prdp_cell import prdp_pkg::*; #(
  parameter int PAGE_BITS = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wave_t                wave_in,
  input  logic [PAGE_BITS-1:0] key_in,
  input  logic [PAGE_BITS-1:0] carry_in,
  input  logic                 set_reused,
  output wave_t                wave_out,
  output logic [PAGE_BITS-1:0] key_out,
  output logic [PAGE_BITS-1:0] carry_out
);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic                 reused;
  wave_t                wave_next;
  logic [PAGE_BITS-1:0] carry_next;
  logic                 take;
  logic                 match;

  assign take  = wave_in.active && !wave_in.found;
  assign match = take && valid && (page == key_in);

  always_comb begin
    wave_next  = wave_in;
    carry_next = carry_in;
    if (match) begin
      wave_next.found        = 1'b1;
      wave_next.match_reused = reused;
    end else if (take) begin
      // hand the old entry one place deeper
      wave_next.carry_valid  = valid;
      wave_next.carry_reused = reused;
      carry_next             = page;
      wave_next.stack_pos    = (wave_in.stack_pos == BIN_LAST) ? wave_in.stack_pos
                                                               : wave_in.stack_pos + BIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      reused <= 1'b0;
    end else begin
      if (take) begin
        valid  <= wave_in.carry_valid;
        reused <= wave_in.carry_reused;
      end
      if (set_reused) begin
        reused <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.active <= 1'b0;
    end else begin
      wave_out.active <= wave_next.active;
    end
    if (take) begin
      page <= carry_in;
    end
    wave_out.found        <= wave_next.found;
    wave_out.match_reused <= wave_next.match_reused;
    wave_out.carry_valid  <= wave_next.carry_valid;
    wave_out.carry_reused <= wave_next.carry_reused;
    wave_out.stack_pos    <= wave_next.stack_pos;
    key_out               <= key_in;
    carry_out             <= carry_next;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for page_reuse_distance_profiler_top: random and directed
// words against a built-in LRU stack predictor. Depends on prdp_pkg and the RTL.
module tb_top;
  import prdp_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int PAGE_W      = 36;
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;
  localparam int MAX_GAP       = 16;
  localparam int WORD_TARGET   = 1200;
  localparam int MAX_REPORTS   = 10;

  // One input word plus the sender's pacing for it.
  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [BIN_W-1:0]  bin_index;
    int unsigned       gap;    // idle cycles before this word goes out
    bit                drain;  // hold this word until every result has come back
  } word_t;

  typedef struct packed {
    logic             hit;
    logic [BIN_W-1:0] distance;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] reused_pages;
    logic [CNT_W-1:0] bin_count;
  } result_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              mode      = MODE_RECORD;
  logic [ADDR_W-1:0] address   = '0;
  logic [BIN_W-1:0]  bin_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic [BIN_W-1:0]  distance;
  logic [CNT_W-1:0]  access_total;
  logic [CNT_W-1:0]  miss_total;
  logic [CNT_W-1:0]  reused_pages;
  logic [CNT_W-1:0]  bin_count;

  page_reuse_distance_profiler_top #(
    .DEPTH    (STACK_DEPTH),
    .PAGE_BITS(PAGE_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .address     (address),
    .bin_index   (bin_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .distance    (distance),
    .access_total(access_total),
    .miss_total  (miss_total),
    .reused_pages(reused_pages),
    .bin_count   (bin_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard stop; the slowest legal run needs well under a fifth of this.
  initial begin
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Recency stack predictor: its own copy of the stack, histogram and totals.
  // ---------------------------------------------------------------------------
  logic [PAGE_W-1:0] lru_page   [0:STACK_DEPTH-1];
  logic              lru_valid  [0:STACK_DEPTH-1];
  logic              lru_reused [0:STACK_DEPTH-1];
  logic [CNT_W-1:0]  reuse_hist [0:NUM_BINS-1];
  logic [CNT_W-1:0]  n_access, n_miss, n_reused;

  int hit_words, miss_words, read_words, last_bin_hits;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic predict_profile(input word_t w, output result_t r);
    int               pos;
    int               top;
    int               i;
    logic [PAGE_W-1:0] pg;
    logic [BIN_W-1:0] hit_depth;
    logic             mark;
    r = '0;
    if (w.mode == MODE_READ) begin
      r.bin_count = reuse_hist[w.bin_index];
      read_words++;
    end else begin
      pg  = w.address[ADDR_W-1:PAGE_SHIFT];
      pos = STACK_DEPTH;
      // Search from the bottom so the shallowest match wins.
      for (i = STACK_DEPTH - 1; i >= 0; i--)
        if (lru_valid[i] && lru_page[i] == pg) pos = i;
      n_access = bump(n_access);
      if (pos < STACK_DEPTH) begin
        // Fold every depth past the last bin into the last bin.
        hit_depth = (pos >= NUM_BINS - 1) ? BIN_LAST : BIN_W'(pos);
        r.hit      = 1'b1;
        r.distance = hit_depth;
        reuse_hist[hit_depth] = bump(reuse_hist[hit_depth]);
        if (!lru_reused[pos]) n_reused = bump(n_reused);
        top  = pos;
        mark = 1'b1;
        hit_words++;
        if (hit_depth == BIN_LAST) last_bin_hits++;
      end else begin
        // Miss: push and let the deepest entry fall off.
        n_miss = bump(n_miss);
        top  = STACK_DEPTH - 1;
        mark = 1'b0;
        miss_words++;
      end
      for (i = top; i > 0; i--) begin
        lru_page[i]   = lru_page[i-1];
        lru_valid[i]  = lru_valid[i-1];
        lru_reused[i] = lru_reused[i-1];
      end
      lru_page[0]   = pg;
      lru_valid[0]  = 1'b1;
      lru_reused[0] = mark;
    end
    r.access_total = n_access;
    r.miss_total   = n_miss;
    r.reused_pages = n_reused;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pull words from the pending queue, honor gaps and drain requests.
  // ---------------------------------------------------------------------------
  word_t   pending_words[$];
  result_t expected_results[$];
  word_t   word_on_port;
  result_t predicted;
  int      idle_cycles;
  bit      fire, launch;

  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      idle_cycles = 0;
      n_access    = '0;
      n_miss      = '0;
      n_reused    = '0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        lru_page[i]   = '0;
        lru_valid[i]  = 1'b0;
        lru_reused[i] = 1'b0;
      end
      for (int i = 0; i < NUM_BINS; i++) reuse_hist[i] = '0;
    end else begin
      fire   = in_valid && in_ready;
      launch = 1'b0;
      if (fire) begin
        predict_profile(word_on_port, predicted);
        expected_results.push_back(predicted);
        idle_cycles = 0;
      end
      if (!in_valid || fire) begin
        if (pending_words.size() != 0 && idle_cycles >= pending_words[0].gap &&
            !(pending_words[0].drain && expected_results.size() != 0))
          launch = 1'b1;
        else
          idle_cycles++;
      end
      // At most one update of in_valid per edge: raise for a new word, drop after a take.
      if (launch) begin
        word_on_port = pending_words.pop_front();
        mode      <= word_on_port.mode;
        address   <= word_on_port.address;
        bin_index <= word_on_port.bin_index;
        in_valid  <= 1'b1;
        idle_cycles = 0;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results with random back-pressure and check them in order.
  // ---------------------------------------------------------------------------
  result_t observed, wanted;
  int      stall_left;
  int      stall_draw;
  bit      rx_steady;
  int      fail_count;
  int      checked_count;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
      rx_steady  = 1'b0;
    end else if (out_valid && out_ready) begin
      observed = {hit, distance, access_total, miss_total, reused_pages, bin_count};
      checked_count++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: result %0d arrived with nothing expected", checked_count);
      end else begin
        wanted = expected_results.pop_front();
        if (observed !== wanted) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("ERROR: result %0d expected hit=%0b dist=%0d acc=%0d miss=%0d reused=%0d bin=%0d",
                     checked_count, wanted.hit, wanted.distance, wanted.access_total,
                     wanted.miss_total, wanted.reused_pages, wanted.bin_count);
            $display("       got      hit=%0b dist=%0d acc=%0d miss=%0d reused=%0d bin=%0d",
                     observed.hit, observed.distance, observed.access_total,
                     observed.miss_total, observed.reused_pages, observed.bin_count);
          end
        end
      end
      // Draw the stall before the next result; now and then switch to full rate.
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      stall_draw = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      stall_left = stall_draw;
      out_ready <= (stall_draw == 0);
    end else if (!out_ready) begin
      if (stall_left > 1) stall_left--;
      else begin
        stall_left = 0;
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  logic [PAGE_W-1:0] page_pool [0:79];

  task automatic add_word(input logic m, input logic [ADDR_W-1:0] a,
                          input logic [BIN_W-1:0] b, input int unsigned gap, input bit drain);
    word_t w;
    w.mode      = m;
    w.address   = a;
    w.bin_index = b;
    w.gap       = gap;
    w.drain     = drain;
    pending_words.push_back(w);
  endtask

  function automatic int unsigned draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int          seg_kind, seg_len, pool_n, sweep_n, pick, j, p;
    bit          burst, drain, first_seg;
    logic [63:0] rnd;

    // Directed: reads at reset, page extremes, same-page offsets, shallow hits.
    add_word(MODE_READ,   48'hFFFF_FFFF_FFFF, 6'd0,  0, 0);
    add_word(MODE_READ,   48'h0,              6'd63, 0, 0);
    add_word(MODE_RECORD, 48'h0,              6'd63, 0, 0);  // page zero, empty stack
    add_word(MODE_RECORD, 48'h0000_0000_0FFF, 6'd0,  0, 0);  // same page, hit at top
    add_word(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 6'd0,  3, 0);  // highest page
    add_word(MODE_RECORD, 48'hFFFF_FFFF_F000, 6'd63, 0, 0);
    add_word(MODE_RECORD, 48'h0000_0000_0800, 6'd0,  0, 0);  // already reused entry
    add_word(MODE_RECORD, 48'h0000_0000_1000, 6'd0,  1, 0);
    add_word(MODE_RECORD, 48'h0000_0000_1ABC, 6'd0,  0, 0);
    add_word(MODE_RECORD, 48'hFFFF_FFFF_F123, 6'd0,  0, 0);  // hit at depth 2
    add_word(MODE_RECORD, 48'hAAAA_AAAA_A555, 6'd21, 0, 0);
    add_word(MODE_RECORD, 48'h5555_5555_5AAA, 6'd42, 0, 0);
    add_word(MODE_RECORD, 48'hAAAA_AAAA_AFFF, 6'd0,  2, 0);
    add_word(MODE_READ,   48'h0,              6'd0,  0, 1);  // wait for drain first
    add_word(MODE_READ,   48'h5555_5555_5555, 6'd1,  0, 0);
    add_word(MODE_READ,   48'hAAAA_AAAA_AAAA, 6'd2,  5, 0);
    add_word(MODE_READ,   48'h0,              6'd63, 0, 0);

    // Random: working-set segments, stack sweeps and bursts of bin reads.
    first_seg = 1'b1;
    while (pending_words.size() < WORD_TARGET) begin
      seg_kind = first_seg ? 7 : $urandom_range(0, 9);
      burst    = ($urandom_range(0, 2) == 0);
      drain    = first_seg || ($urandom_range(0, 3) == 0);
      if (seg_kind <= 6) begin
        // Reuse a pool of pages; pools larger than the stack force evictions.
        pool_n  = $urandom_range(1, 80);
        seg_len = $urandom_range(30, 90);
        for (p = 0; p < pool_n; p++) begin
          rnd = rand64();
          page_pool[p] = rnd[PAGE_W-1:0];
        end
        for (j = 0; j < seg_len; j++) begin
          rnd  = rand64();
          pick = $urandom_range(0, 99);
          if (pick < 84)
            add_word(MODE_RECORD, {page_pool[$urandom_range(0, pool_n - 1)], rnd[11:0]},
                     rnd[BIN_W+11:12], draw_gap(burst), drain && j == 0);
          else if (pick < 94)
            add_word(MODE_READ, rnd[ADDR_W-1:0], rnd[BIN_W+47:48], draw_gap(burst),
                     drain && j == 0);
          else
            add_word(MODE_RECORD, rnd[ADDR_W-1:0], rnd[BIN_W+47:48], draw_gap(burst),
                     drain && j == 0);
        end
      end else if (seg_kind == 7) begin
        // Walk the same page list three times; 64 pages gives hits in the last bin,
        // more than 64 gives nothing but misses through eviction.
        sweep_n = first_seg ? STACK_DEPTH : $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 2);
        for (p = 0; p < sweep_n; p++) begin
          rnd = rand64();
          page_pool[p] = rnd[PAGE_W-1:0];
        end
        for (j = 0; j < 3 * sweep_n; j++) begin
          rnd = rand64();
          add_word(MODE_RECORD, {page_pool[j % sweep_n], rnd[11:0]}, rnd[BIN_W+11:12],
                   draw_gap(burst), drain && j == 0);
        end
        for (j = NUM_BINS - 4; j < NUM_BINS; j++) begin
          rnd = rand64();
          add_word(MODE_READ, rnd[ADDR_W-1:0], BIN_W'(j), draw_gap(burst), 1'b0);
        end
      end else begin
        for (j = 0; j < 8; j++) begin
          rnd = rand64();
          add_word(MODE_READ, rnd[ADDR_W-1:0], rnd[BIN_W+47:48], draw_gap(burst),
                   drain && j == 0);
        end
      end
      first_seg = 1'b0;
    end

    // Let everything drain, then cover the block's full lookup latency.
    wait (!rst);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (STACK_DEPTH + 16) @(negedge clk);

    $display("Run summary: %0d record hits (%0d folded into the last bin), %0d misses,",
             hit_words, last_bin_hits, miss_words);
    $display("             %0d bin reads; %0d results checked, %0d failures",
             read_words, checked_count, fail_count);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
